[sv/sbct_pkg.sv]
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared types and constants for the swept box collision test core.
// ----------------------------------------------------------------------------
package sbct_pkg;

  // fixed field widths
  localparam int MOVE_BITS    = 24;
  localparam int CONTACT_BITS = 24;
  localparam int TOUT_BITS    = 32;

  // slab times are 64 bit signed fixed point
  typedef logic signed [63:0] time_t;

  localparam time_t T_BIG     = 64'sh2000_0000_0000_0000;
  localparam time_t T_NEG_BIG = 64'shE000_0000_0000_0000;
  localparam time_t T_NEG_INF = 64'sh8000_0000_0000_0000;
  localparam time_t T_POS_INF = 64'sh7FFF_FFFF_FFFF_FFFF;

  // face normal codes
  typedef enum logic [2:0] {
    NORM_NONE  = 3'd0,
    NORM_POS_X = 3'd1,
    NORM_NEG_X = 3'd2,
    NORM_POS_Y = 3'd3,
    NORM_NEG_Y = 3'd4
  } norm_t;

  // per item result flags carried down the back end
  typedef struct packed {
    logic                 miss;
    logic                 hit;
    logic                 neg_inf;
    logic                 tneg;
    norm_t                normal;
    logic [TOUT_BITS-1:0] tsat;
  } slab_res_t;

endpackage

[sv/sbct_div.sv]
// ----------------------------------------------------------------------------
// sbct_div
// Pipelined restoring divider: one quotient bit per register stage.
// Dividend is the magnitude shifted left by SHIFT bits.
// ----------------------------------------------------------------------------
module sbct_div import sbct_pkg::*; #(
  parameter int MAG_W = 17,
  parameter int SHIFT = 24
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [MAG_W-1:0]         num_mag,
  input  logic [MOVE_BITS-1:0]     den_mag,
  output logic [MAG_W+SHIFT-1:0]   quo,
  output logic                     rem_nz
);

  localparam int QUO_W = MAG_W + SHIFT;

  logic [QUO_W-1:0]     nq_in   [QUO_W];
  logic [MOVE_BITS-1:0] rem_in  [QUO_W];
  logic [MOVE_BITS-1:0] den_in  [QUO_W];
  logic [QUO_W-1:0]     nq_nxt  [QUO_W];
  logic [MOVE_BITS-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0]     nq_r    [QUO_W];
  logic [MOVE_BITS-1:0] rem_r   [QUO_W];
  logic [MOVE_BITS-1:0] den_r   [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [MOVE_BITS:0] trial;
    logic [MOVE_BITS:0] diff;
    logic               ge;

    // stage input: fresh operands or previous stage
    if (i == 0) begin : g_first
      assign nq_in[i]  = {num_mag, {SHIFT{1'b0}}};
      assign rem_in[i] = '0;
      assign den_in[i] = den_mag;
    end else begin : g_next
      assign nq_in[i]  = nq_r[i-1];
      assign rem_in[i] = rem_r[i-1];
      assign den_in[i] = den_r[i-1];
    end

    // trial subtract of the divisor
    assign trial      = {rem_in[i], nq_in[i][QUO_W-1]};
    assign diff       = trial - {1'b0, den_in[i]};
    assign ge         = (trial >= {1'b0, den_in[i]});
    assign rem_nxt[i] = ge ? diff[MOVE_BITS-1:0] : trial[MOVE_BITS-1:0];
    assign nq_nxt[i]  = {nq_in[i][QUO_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[i]  <= nq_nxt[i];
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_in[i];
      end
    end
  end

  assign quo    = nq_r[QUO_W-1];
  assign rem_nz = |rem_r[QUO_W-1];

endmodule

[sv/swept_box_collision_test_core.sv]
// ----------------------------------------------------------------------------
// swept_box_collision_test_core
// Swept box versus still box test: grown-box slab test on the center ray.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer in and one result out per cycle while the output
// is not stalled. Most of the pipeline depth is the four slab dividers, which
// produce one quotient bit per stage. A stalled output freezes the whole
// pipeline, so in_stall follows out_stall while a result is waiting.
// ----------------------------------------------------------------------------
module swept_box_collision_test_core import sbct_pkg::*; #(
  parameter int COORD_BITS     = 16,
  parameter int MOVE_FRAC_BITS = 8,
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       in_dyn_x,
  input  logic [COORD_BITS-1:0]       in_dyn_y,
  input  logic [COORD_BITS-2:0]       in_dyn_w,
  input  logic [COORD_BITS-2:0]       in_dyn_h,
  input  logic [COORD_BITS-1:0]       in_st_x,
  input  logic [COORD_BITS-1:0]       in_st_y,
  input  logic [COORD_BITS-2:0]       in_st_w,
  input  logic [COORD_BITS-2:0]       in_st_h,
  input  logic [MOVE_BITS-1:0]        in_move_dx,
  input  logic [MOVE_BITS-1:0]        in_move_dy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic                        out_reaches,
  output logic [TOUT_BITS-1:0]        out_t_near_out,
  output logic [CONTACT_BITS-1:0]     out_contact_x,
  output logic [CONTACT_BITS-1:0]     out_contact_y,
  output logic [2:0]                  out_normal_code
);

  localparam int CB    = COORD_BITS;
  localparam int MF    = MOVE_FRAC_BITS;
  localparam int TF    = TIME_FRAC_BITS;
  localparam int SCALE = MF + TF;
  localparam int MAG_W = CB + 1;
  localparam int QUO_W = MAG_W + SCALE;

  // stage indexes
  localparam int S_DIV = QUO_W;
  localparam int S_C1  = S_DIV + 1;
  localparam int S_C2  = S_DIV + 2;
  localparam int S_D1  = S_DIV + 3;
  localparam int S_D2  = S_DIV + 4;
  localparam int S_D3  = S_DIV + 5;
  localparam int S_MUL = S_DIV + 6;
  localparam int S_SUM = S_DIV + 7;
  localparam int S_TR1 = S_DIV + 8;
  localparam int S_TR2 = S_DIV + 9;
  localparam int S_OUT = S_DIV + 10;
  localparam int LAT   = S_OUT + 1;

  localparam logic [63:0] NUM_LIM  = 64'd1 << (61 - SCALE);
  localparam time_t       T_ONE    = time_t'(64'sd1 <<< TF);
  localparam time_t       TOUT_HI  = time_t'((64'sd1 <<< (TOUT_BITS - 1)) - 64'sd1);
  localparam time_t       TOUT_LO  = time_t'(-(64'sd1 <<< (TOUT_BITS - 1)));
  localparam logic [85:0] P_LIM    = 86'd1 << 62;
  localparam logic [85:0] CEIL_ADD = (86'd1 << TF) - 86'd1;
  localparam time_t       TERM_BIG = time_t'(64'sd1 <<< (62 - TF));
  localparam logic signed [64:0] CT_HI = (65'sd1 <<< (CONTACT_BITS - 1)) - 65'sd1;
  localparam logic signed [64:0] CT_LO = -(65'sd1 <<< (CONTACT_BITS - 1));

  // per item data that rides alongside the dividers
  typedef struct packed {
    logic signed [CB:0]   ox;
    logic signed [CB:0]   oy;
    logic [MOVE_BITS-1:0] mx;
    logic [MOVE_BITS-1:0] my;
    logic                 zx;
    logic                 zy;
    logic                 inx;
    logic                 iny;
    logic [3:0]           nneg;
    logic [3:0]           clp;
  } side_t;

  function automatic logic [CB:0] num_mag(input logic [CB+1:0] n);
    logic [CB+1:0] a;
    a = n[CB+1] ? (~n + 1'b1) : n;
    return a[CB:0];
  endfunction

  function automatic time_t time_of(input logic [QUO_W-1:0] q, input logic rnz,
                                    input logic neg, input logic clp);
    logic [63:0] qq;
    time_t       t;
    qq = 64'(q);
    if (clp)      t = neg ? T_NEG_BIG : T_BIG;
    else if (neg) t = ~qq + {63'd0, ~rnz};
    else          t = qq;
    return t;
  endfunction

  function automatic logic [CONTACT_BITS-1:0] sat_contact(input logic signed [64:0] s);
    logic signed [64:0] v;
    if (s > CT_HI)      v = CT_HI;
    else if (s < CT_LO) v = CT_LO;
    else                v = s;
    return v[CONTACT_BITS-1:0];
  endfunction

  function automatic time_t d1_nxgt_sel(input logic sel, input time_t a, input time_t b);
    return sel ? a : b;
  endfunction

  logic adv;
  logic v_r [LAT];

  // whole pipeline moves unless a finished result is held
  assign adv      = !(v_r[LAT-1] && out_stall);
  assign in_stall = !adv;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  // ---------------- stage A: centers, grown box, numerators ----------------
  logic [CB+1:0]        nl_x, nh_x, nl_y, nh_y;
  logic [CB:0]          mag_nxt [4];
  logic [MOVE_BITS-1:0] dmx_nxt, dmy_nxt;
  side_t                side_nxt;
  logic [CB:0]          mag_r [4];
  logic [MOVE_BITS-1:0] dmx_r, dmy_r;
  side_t                side_r [S_OUT];

  always_comb begin
    nl_x = {{2{in_st_x[CB-1]}}, in_st_x} - {{2{in_dyn_x[CB-1]}}, in_dyn_x}
         - {3'b000, in_dyn_w[CB-2:1], 1'b0};
    nh_x = nl_x + {3'b000, in_dyn_w} + {3'b000, in_st_w};
    nl_y = {{2{in_st_y[CB-1]}}, in_st_y} - {{2{in_dyn_y[CB-1]}}, in_dyn_y}
         - {3'b000, in_dyn_h[CB-2:1], 1'b0};
    nh_y = nl_y + {3'b000, in_dyn_h} + {3'b000, in_st_h};

    mag_nxt[0] = num_mag(nl_x);
    mag_nxt[1] = num_mag(nh_x);
    mag_nxt[2] = num_mag(nl_y);
    mag_nxt[3] = num_mag(nh_y);
    dmx_nxt    = in_move_dx[MOVE_BITS-1] ? (~in_move_dx + 1'b1) : in_move_dx;
    dmy_nxt    = in_move_dy[MOVE_BITS-1] ? (~in_move_dy + 1'b1) : in_move_dy;

    side_nxt.ox   = {in_dyn_x[CB-1], in_dyn_x} + {3'b000, in_dyn_w[CB-2:1]};
    side_nxt.oy   = {in_dyn_y[CB-1], in_dyn_y} + {3'b000, in_dyn_h[CB-2:1]};
    side_nxt.mx   = in_move_dx;
    side_nxt.my   = in_move_dy;
    side_nxt.zx   = (in_move_dx == '0);
    side_nxt.zy   = (in_move_dy == '0);
    side_nxt.inx  = nl_x[CB+1] && !nh_x[CB+1] && (nh_x != '0);
    side_nxt.iny  = nl_y[CB+1] && !nh_y[CB+1] && (nh_y != '0);
    side_nxt.nneg = {nh_y[CB+1], nl_y[CB+1], nh_x[CB+1], nl_x[CB+1]};
    for (int j = 0; j < 4; j++) side_nxt.clp[j] = (64'(mag_nxt[j]) > NUM_LIM);
  end

  // ---------------- slab dividers ----------------
  logic [QUO_W-1:0] quo_w [4];
  logic             rnz_w [4];

  for (genvar j = 0; j < 4; j++) begin : g_div
    sbct_div #(
      .MAG_W (MAG_W),
      .SHIFT (SCALE)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (mag_r[j]),
      .den_mag ((j < 2) ? dmx_r : dmy_r),
      .quo     (quo_w[j]),
      .rem_nz  (rnz_w[j])
    );
  end

  // ---------------- back end combinational logic ----------------
  time_t           t_nxt [4];
  time_t           nx_nxt, fx_nxt, ny_nxt, fy_nxt;
  logic            okx_nxt, oky_nxt;
  time_t           tn_nxt;
  logic            miss_nxt;
  norm_t           norm_nxt;
  slab_res_t       res_nxt;
  logic [63:0]     tabs;
  logic [MOVE_BITS-1:0] amx_nxt, amy_nxt;
  logic            pnegx, pnegy;
  logic [85:0]     cx_sh, cy_sh;
  time_t           termx_nxt, termy_nxt;
  logic signed [64:0] sumx, sumy;

  time_t           t_r [4];
  time_t           nx_r, fx_r, ny_r, fy_r;
  logic            okx_r, oky_r;
  time_t           d1_nx_r, d1_fx_r, d1_ny_r, d1_fy_r;
  logic            d1_ok_r, nxfy_r, nyfx_r, nxgt_r, nxlt_r, fxlt_r;
  time_t           tn_r;
  logic            miss_r;
  norm_t           norm_r;
  slab_res_t       res_r [5];
  logic [61:0]     atn_r;
  logic [MOVE_BITS-1:0] amx_r, amy_r;
  logic [54:0]     ppxl_r, ppxh_r, ppyl_r, ppyh_r;
  logic [85:0]     px_r, py_r;
  logic [62:0]     magx_r, magy_r;
  logic            ovfx_r, ovfy_r, pnegx_r, pnegy_r;
  time_t           termx_r, termy_r;
  logic            hit_r, reaches_r;
  logic [TOUT_BITS-1:0]    tout_r;
  logic [CONTACT_BITS-1:0] cx_r, cy_r;
  logic [2:0]      norm_out_r;

  always_comb begin
    // signed floored times from quotient and remainder
    for (int j = 0; j < 4; j++) begin
      t_nxt[j] = time_of(quo_w[j], rnz_w[j],
                         side_r[S_DIV].nneg[j] ^ ((j < 2) ? side_r[S_DIV].mx[MOVE_BITS-1]
                                                          : side_r[S_DIV].my[MOVE_BITS-1]),
                         side_r[S_DIV].clp[j]);
    end

    // per axis near/far, still axes open or closed
    if (side_r[S_C1].zx) begin
      okx_nxt = side_r[S_C1].inx;
      nx_nxt  = T_NEG_INF;
      fx_nxt  = T_POS_INF;
    end else begin
      okx_nxt = 1'b1;
      nx_nxt  = (t_r[0] > t_r[1]) ? t_r[1] : t_r[0];
      fx_nxt  = (t_r[0] > t_r[1]) ? t_r[0] : t_r[1];
    end
    if (side_r[S_C1].zy) begin
      oky_nxt = side_r[S_C1].iny;
      ny_nxt  = T_NEG_INF;
      fy_nxt  = T_POS_INF;
    end else begin
      oky_nxt = 1'b1;
      ny_nxt  = (t_r[2] > t_r[3]) ? t_r[3] : t_r[2];
      fy_nxt  = (t_r[2] > t_r[3]) ? t_r[2] : t_r[3];
    end

    // entry time, miss and normal choice
    tn_nxt   = d1_nxgt_sel(nxgt_r, d1_nx_r, d1_ny_r);
    miss_nxt = !d1_ok_r || nxfy_r || nyfx_r
            || (fxlt_r ? d1_fx_r[63] : d1_fy_r[63]);
    if (nxgt_r)
      norm_nxt = side_r[S_D1].mx[MOVE_BITS-1] ? NORM_POS_X : NORM_NEG_X;
    else if (nxlt_r)
      norm_nxt = side_r[S_D1].my[MOVE_BITS-1] ? NORM_POS_Y : NORM_NEG_Y;
    else
      norm_nxt = NORM_NONE;

    // entry time flags, saturation and magnitude
    res_nxt.miss    = miss_r;
    res_nxt.normal  = norm_r;
    res_nxt.hit     = !tn_r[63] && (tn_r < T_ONE);
    res_nxt.neg_inf = (tn_r == T_NEG_INF);
    res_nxt.tneg    = tn_r[63];
    if (tn_r > TOUT_HI)      res_nxt.tsat = TOUT_HI[TOUT_BITS-1:0];
    else if (tn_r < TOUT_LO) res_nxt.tsat = TOUT_LO[TOUT_BITS-1:0];
    else                     res_nxt.tsat = tn_r[TOUT_BITS-1:0];
    tabs    = tn_r[63] ? (~tn_r + 64'd1) : tn_r;
    amx_nxt = side_r[S_D2].mx[MOVE_BITS-1] ? (~side_r[S_D2].mx + 1'b1) : side_r[S_D2].mx;
    amy_nxt = side_r[S_D2].my[MOVE_BITS-1] ? (~side_r[S_D2].my + 1'b1) : side_r[S_D2].my;

    // floor of the scaled product: round magnitude up when negative
    pnegx = side_r[S_SUM].mx[MOVE_BITS-1] ^ res_r[2].tneg;
    pnegy = side_r[S_SUM].my[MOVE_BITS-1] ^ res_r[2].tneg;
    cx_sh = (pnegx ? (px_r + CEIL_ADD) : px_r) >> TF;
    cy_sh = (pnegy ? (py_r + CEIL_ADD) : py_r) >> TF;

    // signed contact terms
    if (side_r[S_TR1].zx || res_r[3].neg_inf) termx_nxt = '0;
    else if (ovfx_r) termx_nxt = pnegx_r ? -TERM_BIG : TERM_BIG;
    else termx_nxt = pnegx_r ? (~{1'b0, magx_r} + 64'd1) : {1'b0, magx_r};
    if (side_r[S_TR1].zy || res_r[3].neg_inf) termy_nxt = '0;
    else if (ovfy_r) termy_nxt = pnegy_r ? -TERM_BIG : TERM_BIG;
    else termy_nxt = pnegy_r ? (~{1'b0, magy_r} + 64'd1) : {1'b0, magy_r};

    // contact point
    sumx = (65'(side_r[S_TR2].ox) <<< MF) + 65'(termx_r);
    sumy = (65'(side_r[S_TR2].oy) <<< MF) + 65'(termy_r);
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage A
      for (int j = 0; j < 4; j++) mag_r[j] <= mag_nxt[j];
      dmx_r     <= dmx_nxt;
      dmy_r     <= dmy_nxt;
      side_r[0] <= side_nxt;
      for (int k = 1; k < S_OUT; k++) side_r[k] <= side_r[k-1];
      // C1, C2
      for (int j = 0; j < 4; j++) t_r[j] <= t_nxt[j];
      nx_r  <= nx_nxt;
      fx_r  <= fx_nxt;
      ny_r  <= ny_nxt;
      fy_r  <= fy_nxt;
      okx_r <= okx_nxt;
      oky_r <= oky_nxt;
      // D1: overlap and ordering compares
      d1_nx_r <= nx_r;
      d1_fx_r <= fx_r;
      d1_ny_r <= ny_r;
      d1_fy_r <= fy_r;
      d1_ok_r <= okx_r && oky_r;
      nxfy_r  <= (nx_r > fy_r);
      nyfx_r  <= (ny_r > fx_r);
      nxgt_r  <= (nx_r > ny_r);
      nxlt_r  <= (nx_r < ny_r);
      fxlt_r  <= (fx_r < fy_r);
      // D2
      tn_r   <= tn_nxt;
      miss_r <= miss_nxt;
      norm_r <= norm_nxt;
      // D3
      res_r[0] <= res_nxt;
      for (int k = 1; k < 5; k++) res_r[k] <= res_r[k-1];
      atn_r <= tabs[61:0];
      amx_r <= amx_nxt;
      amy_r <= amy_nxt;
      // partial products
      ppxl_r <= amx_r * atn_r[30:0];
      ppxh_r <= amx_r * atn_r[61:31];
      ppyl_r <= amy_r * atn_r[30:0];
      ppyh_r <= amy_r * atn_r[61:31];
      // product sum
      px_r <= {ppxh_r, 31'd0} + 86'(ppxl_r);
      py_r <= {ppyh_r, 31'd0} + 86'(ppyl_r);
      // overflow and scaled magnitude
      ovfx_r  <= (px_r > P_LIM);
      ovfy_r  <= (py_r > P_LIM);
      pnegx_r <= pnegx;
      pnegy_r <= pnegy;
      magx_r  <= cx_sh[62:0];
      magy_r  <= cy_sh[62:0];
      // terms
      termx_r <= termx_nxt;
      termy_r <= termy_nxt;
      // output register, a miss clears every field
      hit_r      <= !res_r[4].miss && res_r[4].hit;
      reaches_r  <= !res_r[4].miss;
      tout_r     <= res_r[4].miss ? '0 : res_r[4].tsat;
      cx_r       <= res_r[4].miss ? '0 : sat_contact(sumx);
      cy_r       <= res_r[4].miss ? '0 : sat_contact(sumy);
      norm_out_r <= res_r[4].miss ? NORM_NONE : res_r[4].normal;
    end
  end

  assign out_valid       = v_r[LAT-1];
  assign out_hit         = hit_r;
  assign out_reaches     = reaches_r;
  assign out_t_near_out  = tout_r;
  assign out_contact_x   = cx_r;
  assign out_contact_y   = cy_r;
  assign out_normal_code = norm_out_r;

`ifndef ASSERT_OFF
  // a hit is always a reach
  a_hit_reach : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_reaches)
    else $error("hit without reach");

  // a miss reports all fields as zero
  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reaches |-> out_normal_code == NORM_NONE
      && out_t_near_out == '0 && out_contact_x == '0 && out_contact_y == '0)
    else $error("miss with nonzero fields");

  // a hit has a non-negative entry time
  a_hit_time : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_t_near_out[TOUT_BITS-1])
    else $error("hit with negative entry time");

  // a held result stops intake
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("intake while result held");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for swept_box_collision_test_core. A clocked driver feeds box
// pairs from a queue and a clocked monitor checks each result field by field
// against an in-order queue of predicted collision results.
// ----------------------------------------------------------------------------
module tb_top import sbct_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] dyn_x, dyn_y;
    logic        [14:0] dyn_w, dyn_h;
    logic signed [15:0] st_x, st_y;
    logic        [14:0] st_w, st_h;
    logic signed [23:0] move_dx, move_dy;
  } box_pair_t;

  typedef struct {
    logic               hit;
    logic               reaches;
    logic signed [31:0] t_near;
    logic signed [23:0] cx, cy;
    norm_t              normal;
  } collision_t;

  localparam longint T_BIG_L  = 64'sh2000_0000_0000_0000;
  localparam longint T_NINF_L = 64'sh8000_0000_0000_0000;
  localparam longint T_PINF_L = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int     LIMIT    = 300000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_dyn_x = '0, in_dyn_y = '0, in_st_x = '0, in_st_y = '0;
  logic [14:0] in_dyn_w = '0, in_dyn_h = '0, in_st_w = '0, in_st_h = '0;
  logic [23:0] in_move_dx = '0, in_move_dy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit, out_reaches;
  logic [31:0] out_t_near_out;
  logic [23:0] out_contact_x, out_contact_y;
  logic [2:0] out_normal_code;

  box_pair_t  pending_pairs[$];
  collision_t expected_hits[$];
  int errors = 0;
  int cyc = 0;

  swept_box_collision_test_core DUT (.*);

  always #2 clk = ~clk;

  function automatic longint floor_div(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic longint sat_to(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -(64'sd1 <<< (bits - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint edge_time(longint num, longint d);
    longint lim;
    lim = T_BIG_L >>> 24;
    if (num > lim || num < -lim) return ((num < 0) != (d < 0)) ? -T_BIG_L : T_BIG_L;
    return floor_div(num * (64'sd1 <<< 24), d);
  endfunction

  // entry and exit times of one axis, 0 when a still axis misses
  function automatic bit axis_span(longint lo, longint hi, longint o, longint d,
                                   output longint tn, output longint tf);
    longint k;
    tn = 0;
    tf = 0;
    if (d == 0) begin
      if (lo < o && o < hi) begin
        tn = T_NINF_L;
        tf = T_PINF_L;
        return 1;
      end
      return 0;
    end
    tn = edge_time(lo - o, d);
    tf = edge_time(hi - o, d);
    if (tn > tf) begin
      k = tn;
      tn = tf;
      tf = k;
    end
    return 1;
  endfunction

  function automatic longint contact_coord(longint o, longint d, longint t);
    longint base, term, ad, at, big;
    base = o * 256;
    if (d != 0) begin
      ad = d < 0 ? -d : d;
      at = t < 0 ? -t : t;
      if (at > ((64'sd1 <<< 62) / ad)) begin
        big = (64'sd1 <<< 62) >>> 16;
        term = ((d < 0) != (t < 0)) ? -big : big;
      end else begin
        term = floor_div(d * t, 64'sd65536);
      end
      base += term;
    end
    return sat_to(base, 24);
  endfunction

  function automatic collision_t predict_collision(box_pair_t p);
    collision_t r;
    longint dw, dh, ox, oy, lx, ly, hx, hy, mx, my, nx, fx, ny, fy, tn, tf;
    r = '{hit: 1'b0, reaches: 1'b0, t_near: '0, cx: '0, cy: '0, normal: NORM_NONE};
    dw = longint'(p.dyn_w);
    dh = longint'(p.dyn_h);
    ox = longint'(p.dyn_x) + (dw >>> 1);
    oy = longint'(p.dyn_y) + (dh >>> 1);
    lx = longint'(p.st_x) - (dw >>> 1);
    ly = longint'(p.st_y) - (dh >>> 1);
    hx = lx + dw + longint'(p.st_w);
    hy = ly + dh + longint'(p.st_h);
    mx = longint'(p.move_dx);
    my = longint'(p.move_dy);
    if (!axis_span(lx, hx, ox, mx, nx, fx)) return r;
    if (!axis_span(ly, hy, oy, my, ny, fy)) return r;
    if (nx > fy || ny > fx) return r;
    tn = nx > ny ? nx : ny;
    tf = fx < fy ? fx : fy;
    if (tf < 0) return r;
    r.reaches = 1'b1;
    r.hit = (tn >= 0 && tn < 64'sd65536);
    r.t_near = 32'(sat_to(tn, 32));
    if (tn == T_NINF_L) begin
      r.cx = 24'(sat_to(ox * 256, 24));
      r.cy = 24'(sat_to(oy * 256, 24));
    end else begin
      r.cx = 24'(contact_coord(ox, mx, tn));
      r.cy = 24'(contact_coord(oy, my, tn));
    end
    if (nx > ny) r.normal = mx < 0 ? NORM_POS_X : NORM_NEG_X;
    else if (nx < ny) r.normal = my < 0 ? NORM_POS_Y : NORM_NEG_Y;
    return r;
  endfunction

  // idle on about 7 in 100 calls, never inside the quiet window
  function automatic bit take_break();
    if (cyc > 300 && cyc < 600) return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // driver: load the next pair once the current one has transferred
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_pairs.size() > 0 && !take_break()) begin
        box_pair_t p;
        p = pending_pairs.pop_front();
        in_valid   <= 1'b1;
        in_dyn_x   <= p.dyn_x;
        in_dyn_y   <= p.dyn_y;
        in_dyn_w   <= p.dyn_w;
        in_dyn_h   <= p.dyn_h;
        in_st_x    <= p.st_x;
        in_st_y    <= p.st_y;
        in_st_w    <= p.st_w;
        in_st_h    <= p.st_h;
        in_move_dx <= p.move_dx;
        in_move_dy <= p.move_dy;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= take_break();
  end

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      box_pair_t p;
      p = '{in_dyn_x, in_dyn_y, in_dyn_w, in_dyn_h, in_st_x, in_st_y,
            in_st_w, in_st_h, in_move_dx, in_move_dy};
      expected_hits.push_back(predict_collision(p));
    end
  end

  // result transfers are checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer at cycle %0d", cyc);
      end else begin
        collision_t e;
        e = expected_hits.pop_front();
        if (out_hit !== e.hit || out_reaches !== e.reaches ||
            out_t_near_out !== e.t_near || out_contact_x !== e.cx ||
            out_contact_y !== e.cy || out_normal_code !== e.normal) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0b %0b %h %h %h %0d | got %0b %0b %h %h %h %0d",
                     e.hit, e.reaches, e.t_near, e.cx, e.cy, e.normal, out_hit,
                     out_reaches, out_t_near_out, out_contact_x, out_contact_y,
                     out_normal_code);
        end
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic box_pair_t mk(int dx, int dy, int dw, int dh, int sx, int sy,
                                   int sw, int sh, int mx, int my);
    box_pair_t p;
    p = '{16'(dx), 16'(dy), 15'(dw), 15'(dh), 16'(sx), 16'(sy), 15'(sw), 15'(sh),
          24'(mx), 24'(my)};
    return p;
  endfunction

  // pair aimed roughly at the still box, with random content
  function automatic box_pair_t aimed_pair();
    box_pair_t p;
    int sx, sy, sw, sh, dx, dy, dw, dh, tx, ty, k;
    sw = $urandom_range(0, 200);
    sh = $urandom_range(0, 200);
    dw = $urandom_range(0, 100);
    dh = $urandom_range(0, 100);
    sx = $urandom_range(0, 4000) - 2000;
    sy = $urandom_range(0, 4000) - 2000;
    dx = sx + $urandom_range(0, 3000) - 1500;
    dy = sy + $urandom_range(0, 3000) - 1500;
    tx = (sx + sw / 2) - (dx + dw / 2);
    ty = (sy + sh / 2) - (dy + dh / 2);
    k = $urandom_range(0, 8);
    tx = tx * 64 * k + $urandom_range(0, 511) - 256;
    ty = ty * 64 * k + $urandom_range(0, 511) - 256;
    case ($urandom_range(0, 9))
      0: tx = 0;
      1: ty = 0;
      2: dx = sx - dw / 2 - dw / 2;  // center on the grown left edge
      3: dy = sy - dh / 2 - dh / 2;
      4: ty = (tx / 256) * 256;      // near-diagonal moves for ties
      default: ;
    endcase
    p = mk(dx, dy, dw, dh, sx, sy, sw, sh, tx, ty);
    return p;
  endfunction

  function automatic box_pair_t noise_pair();
    box_pair_t p;
    p = '{16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
          16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
          24'($urandom), 24'($urandom)};
    return p;
  endfunction

  initial begin
    // directed pairs
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk(0, 0, 10, 10, 2, 2, 20, 20, 0, 0));          // still, inside
    pending_pairs.push_back(mk(0, 0, 10, 10, 5, 0, 20, 20, 0, 256));        // on an edge, still x
    pending_pairs.push_back(mk(0, 0, 10, 10, 100, 0, 10, 10, 51200, 0));    // -x face
    pending_pairs.push_back(mk(200, 0, 10, 10, 100, 0, 10, 10, -51200, 0)); // +x face
    pending_pairs.push_back(mk(0, 0, 10, 10, 0, 100, 10, 10, 0, 51200));    // -y face
    pending_pairs.push_back(mk(0, 200, 10, 10, 0, 100, 10, 10, 0, -51200)); // +y face
    pending_pairs.push_back(mk(0, 0, 10, 10, 100, 100, 10, 10, 25600, 25600)); // tie
    pending_pairs.push_back(mk(0, 0, 10, 10, 100, 0, 10, 10, -2560, 1));    // moving away
    pending_pairs.push_back(mk(0, 0, 10, 10, 1000, 0, 10, 10, 2560, 1));    // entry after 1
    pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
                               8388607, 8388607));
    pending_pairs.push_back(mk(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767,
                               -8388608, -8388608));
    pending_pairs.push_back(mk(32767, -32768, 0, 0, -32768, 32767, 0, 0, 1, -1));
    pending_pairs.push_back(mk(0, 0, 32767, 32767, 0, 0, 32767, 32767, 0, 0));
    pending_pairs.push_back(mk(-32768, 0, 0, 0, 32767, 0, 0, 2, 1, 0));     // time clamp
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 8388607, -8388608));
    pending_pairs.push_back(mk(0, 0, 4, 4, -5, -5, 10, 10, -1, 1));
    pending_pairs.push_back(mk(0, 0, 1, 1, 3, 0, 1, 1, 1, 0));
    for (int i = 0; i < 900; i++)
      pending_pairs.push_back($urandom_range(0, 99) < 80 ? aimed_pair() : noise_pair());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() > 0 || in_valid) @(posedge clk);
    while (expected_hits.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_hits.size() > 0) errors++;

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
